>>> hdl/wsdf_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// Used by wsdf_front, wsdf_queue, wsdf_back and websocket_frame_deframer.
`default_nettype none

package wsdf_pkg;

    // Widest payload length the design represents internally.
    localparam int LENGTH_BITS = 32;
    localparam logic [31:0] LEN_LIMIT = (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF :
        32'((64'd1 << LENGTH_BITS) - 64'd1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] MSG_MAX_RESET     = 32'd1048576;
    localparam logic [6:0]  CONTROL_MAX_RESET = 7'd125;
    localparam logic [6:0]  CONTROL_CAP       = 7'd125;

    // Configuration register indexes
    localparam logic CFG_MSG_MAX     = 1'b0;
    localparam logic CFG_CONTROL_MAX = 1'b1;

    // Opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_REFUSED = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PROTO = 2'd1,
        ST_BIG   = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] msg_max;
        logic [6:0]  control_max;
    } t_cfg;

    // One classified request from the parser to the output side.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [7:0]  key;
        logic [3:0]  opcode;
        logic        fin;
        logic        last;
        t_status     status;
        logic [31:0] len;
        logic        len_ovf;
    } t_cmd;

endpackage

`default_nettype wire

>>> hdl/websocket_frame_deframer.sv
// WebSocket client-to-server frame deframer, one stream byte per cycle.
// Throughput: one byte per cycle; input stalls only while four requests wait in the queue.
// A result passes from its byte through the parser, a four-entry request queue and the output
// register; it waits in the queue while the output register is full and not popped.
// Reset (synchronous, active low) clears parser, queue and output; registers take
// msg_max 1048576 and control_max 125. Depends on wsdf_pkg, wsdf_front/queue/back.
`default_nettype none

module websocket_frame_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_restart,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_payload_byte,
    output logic [3:0]       o_opcode,
    output logic             o_fin,
    output logic             o_last,
    output logic [1:0]       o_status,
    output logic [31:0]      o_payload_length,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata
);

    wsdf_pkg::t_cfg r_cfg;
    wsdf_pkg::t_cmd front_cmd, queue_cmd;
    logic           accept;
    logic           front_emit;
    logic           queue_avail;
    logic           back_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.msg_max     <= wsdf_pkg::MSG_MAX_RESET;
            r_cfg.control_max <= wsdf_pkg::CONTROL_MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                wsdf_pkg::CFG_MSG_MAX:     r_cfg.msg_max     <= i_cfg_wdata;
                wsdf_pkg::CFG_CONTROL_MAX: r_cfg.control_max <= i_cfg_wdata[6:0];
                default:                   r_cfg             <= r_cfg;
            endcase
        end
    end

    assign accept = i_push && !o_full;

    wsdf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_data_byte (i_data_byte),
        .i_restart   (i_restart),
        .i_cfg       (r_cfg),
        .o_emit      (front_emit),
        .o_cmd       (front_cmd)
    );

    wsdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_emit),
        .i_cmd   (front_cmd),
        .o_full  (o_full),
        .i_rd    (back_take),
        .o_avail (queue_avail),
        .o_cmd   (queue_cmd)
    );

    wsdf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_avail          (queue_avail),
        .i_cmd            (queue_cmd),
        .o_take           (back_take),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_kind           (o_kind),
        .o_payload_byte   (o_payload_byte),
        .o_opcode         (o_opcode),
        .o_fin            (o_fin),
        .o_last           (o_last),
        .o_status         (o_status),
        .o_payload_length (o_payload_length)
    );

    a_plain_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind != wsdf_pkg::KIND_PAYLOAD) |-> (o_payload_byte == 8'd0))
        else $error("non-payload result carries a data byte");

    a_refuse_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind != wsdf_pkg::KIND_PAYLOAD) |-> o_last)
        else $error("empty or refused frame result not marked last");

    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind == wsdf_pkg::KIND_EMPTY) |->
        (o_payload_length == 32'd0 && o_status == wsdf_pkg::ST_OK))
        else $error("frame without payload reports a length or error");

    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind == wsdf_pkg::KIND_PAYLOAD) |->
        (o_status == wsdf_pkg::ST_OK && o_payload_length <= r_cfg.msg_max))
        else $error("payload byte from a frame that should have been refused");

endmodule

`default_nettype wire

>>> hdl/wsdf_front.sv
// Header parser of the deframer: walks each frame, checks it and classifies bytes.
// Depends on wsdf_pkg.
`default_nettype none

module wsdf_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_restart,
    input  wire wsdf_pkg::t_cfg i_cfg,
    output logic                o_emit,
    output wsdf_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        PH_HEAD0,
        PH_HEAD1,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_16,
        FORM_64
    } t_form;

    t_phase      r_phase, c_phase, n_phase;
    t_form       r_form, c_form, n_form;
    logic        r_fin, c_fin, n_fin;
    logic [3:0]  r_op, c_op, n_op;
    logic [31:0] r_acc, c_acc, n_acc;
    logic        r_ovf, c_ovf, n_ovf;
    logic [3:0]  r_ext_left, c_ext_left, n_ext_left;
    logic [31:0] r_key, c_key, n_key;
    logic [1:0]  r_mask_cnt, c_mask_cnt, n_mask_cnt;
    logic [1:0]  r_mpos, c_mpos, n_mpos;
    logic [31:0] r_remain, c_remain, n_remain;
    logic        r_stopped, c_stopped, n_stopped;

    logic [31:0] ld_acc;
    logic        ld_ovf;
    t_form       ld_form;
    logic        ld_refuse;
    wsdf_pkg::t_status ld_status;
    logic [6:0]  cmax;
    logic        op_ok;
    logic [7:0]  key_byte;

    always_comb begin
        // Restart wipes the parser before this byte is looked at.
        if (i_restart) begin
            c_phase    = PH_HEAD0;
            c_form     = FORM_SHORT;
            c_fin      = 1'b0;
            c_op       = '0;
            c_acc      = '0;
            c_ovf      = 1'b0;
            c_ext_left = '0;
            c_key      = '0;
            c_mask_cnt = '0;
            c_mpos     = '0;
            c_remain   = '0;
            c_stopped  = 1'b0;
        end else begin
            c_phase    = r_phase;
            c_form     = r_form;
            c_fin      = r_fin;
            c_op       = r_op;
            c_acc      = r_acc;
            c_ovf      = r_ovf;
            c_ext_left = r_ext_left;
            c_key      = r_key;
            c_mask_cnt = r_mask_cnt;
            c_mpos     = r_mpos;
            c_remain   = r_remain;
            c_stopped  = r_stopped;
        end
    end

    // Length checks, shared by the short form and the last extended length byte.
    always_comb begin
        if (c_phase == PH_HEAD1) begin
            ld_acc  = {25'd0, i_data_byte[6:0]};
            ld_ovf  = 1'b0;
            ld_form = FORM_SHORT;
        end else begin
            ld_acc  = {c_acc[23:0], i_data_byte};
            ld_ovf  = c_ovf | (c_acc[31:24] != 8'd0);
            ld_form = c_form;
        end
        cmax = (i_cfg.control_max > wsdf_pkg::CONTROL_CAP) ? wsdf_pkg::CONTROL_CAP :
            i_cfg.control_max;
        ld_refuse = 1'b1;
        if (ld_form == FORM_16 && ld_acc < 32'd126) begin
            ld_status = wsdf_pkg::ST_PROTO;
        end else if (ld_form == FORM_64 && !ld_ovf && ld_acc < 32'd65536) begin
            ld_status = wsdf_pkg::ST_PROTO;
        end else if (ld_ovf || ld_acc > i_cfg.msg_max || ld_acc > wsdf_pkg::LEN_LIMIT) begin
            ld_status = wsdf_pkg::ST_BIG;
        end else if (c_op[3] && (!c_fin || ld_acc > {25'd0, cmax} ||
                     (c_op == wsdf_pkg::OP_CLOSE && ld_acc == 32'd1))) begin
            ld_status = wsdf_pkg::ST_PROTO;
        end else begin
            ld_status = wsdf_pkg::ST_OK;
            ld_refuse = 1'b0;
        end
    end

    always_comb begin
        op_ok = (i_data_byte[3:0] inside {wsdf_pkg::OP_CONT, wsdf_pkg::OP_TEXT,
            wsdf_pkg::OP_BINARY, wsdf_pkg::OP_CLOSE, wsdf_pkg::OP_PING, wsdf_pkg::OP_PONG});
        case (c_mpos)
            2'd0:    key_byte = c_key[31:24];
            2'd1:    key_byte = c_key[23:16];
            2'd2:    key_byte = c_key[15:8];
            default: key_byte = c_key[7:0];
        endcase
    end

    always_comb begin
        n_phase    = c_phase;
        n_form     = c_form;
        n_fin      = c_fin;
        n_op       = c_op;
        n_acc      = c_acc;
        n_ovf      = c_ovf;
        n_ext_left = c_ext_left;
        n_key      = c_key;
        n_mask_cnt = c_mask_cnt;
        n_mpos     = c_mpos;
        n_remain   = c_remain;
        n_stopped  = c_stopped;
        o_emit     = 1'b0;
        o_cmd      = '0;

        if (!c_stopped) begin
            case (c_phase)
                PH_HEAD0: begin
                    n_fin = i_data_byte[7];
                    n_op  = i_data_byte[3:0];
                    n_acc = '0;
                    n_ovf = 1'b0;
                    if (i_data_byte[6:4] != 3'd0 || !op_ok) begin
                        o_emit         = 1'b1;
                        o_cmd.kind     = wsdf_pkg::KIND_REFUSED;
                        o_cmd.status   = wsdf_pkg::ST_PROTO;
                        o_cmd.last     = 1'b1;
                        n_stopped      = 1'b1;
                    end else begin
                        n_phase = PH_HEAD1;
                    end
                end
                PH_HEAD1: begin
                    if (!i_data_byte[7]) begin
                        o_emit       = 1'b1;
                        o_cmd.kind   = wsdf_pkg::KIND_REFUSED;
                        o_cmd.status = wsdf_pkg::ST_PROTO;
                        o_cmd.last   = 1'b1;
                        n_stopped    = 1'b1;
                        n_phase      = PH_HEAD0;
                    end else if (i_data_byte[6:0] == 7'd126) begin
                        n_form     = FORM_16;
                        n_ext_left = 4'd2;
                        n_phase    = PH_EXTLEN;
                    end else if (i_data_byte[6:0] == 7'd127) begin
                        n_form     = FORM_64;
                        n_ext_left = 4'd8;
                        n_phase    = PH_EXTLEN;
                    end else begin
                        n_form = FORM_SHORT;
                        n_acc  = ld_acc;
                        n_ovf  = ld_ovf;
                    end
                end
                PH_EXTLEN: begin
                    n_acc      = ld_acc;
                    n_ovf      = ld_ovf;
                    n_ext_left = c_ext_left - 4'd1;
                end
                PH_MASK: begin
                    n_key = {c_key[23:0], i_data_byte};
                    if (c_mask_cnt == 2'd3) begin
                        n_mpos   = '0;
                        n_remain = c_acc;
                        if (c_acc == 32'd0) begin
                            o_emit     = 1'b1;
                            o_cmd.kind = wsdf_pkg::KIND_EMPTY;
                            o_cmd.last = 1'b1;
                            n_phase    = PH_HEAD0;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        n_mask_cnt = c_mask_cnt + 2'd1;
                    end
                end
                PH_PAYLOAD: begin
                    n_mpos     = c_mpos + 2'd1;
                    n_remain   = c_remain - 32'd1;
                    o_emit     = 1'b1;
                    o_cmd.kind = wsdf_pkg::KIND_PAYLOAD;
                    o_cmd.data = i_data_byte;
                    o_cmd.key  = key_byte;
                    o_cmd.len  = c_acc;
                    o_cmd.last = (c_remain == 32'd1);
                    if (c_remain == 32'd1) begin
                        n_phase = PH_HEAD0;
                    end
                end
                default: begin
                    n_phase = PH_HEAD0;
                end
            endcase

            // Length now known: refuse, or move on to the mask key.
            if ((c_phase == PH_HEAD1 && i_data_byte[7] && i_data_byte[6:1] != 6'h3F) ||
                (c_phase == PH_EXTLEN && c_ext_left == 4'd1)) begin
                if (ld_refuse) begin
                    o_emit        = 1'b1;
                    o_cmd.kind    = wsdf_pkg::KIND_REFUSED;
                    o_cmd.status  = ld_status;
                    o_cmd.last    = 1'b1;
                    o_cmd.len     = ld_acc;
                    o_cmd.len_ovf = ld_ovf;
                    n_stopped     = 1'b1;
                    n_phase       = PH_HEAD0;
                end else begin
                    n_phase    = PH_MASK;
                    n_mask_cnt = '0;
                    n_key      = '0;
                end
            end
        end

        o_cmd.opcode = n_op;
        o_cmd.fin    = n_fin;
        o_emit       = o_emit & i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEAD0;
            r_form     <= FORM_SHORT;
            r_fin      <= 1'b0;
            r_op       <= '0;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
            r_ext_left <= '0;
            r_key      <= '0;
            r_mask_cnt <= '0;
            r_mpos     <= '0;
            r_remain   <= '0;
            r_stopped  <= 1'b0;
        end else if (i_valid) begin
            r_phase    <= n_phase;
            r_form     <= n_form;
            r_fin      <= n_fin;
            r_op       <= n_op;
            r_acc      <= n_acc;
            r_ovf      <= n_ovf;
            r_ext_left <= n_ext_left;
            r_key      <= n_key;
            r_mask_cnt <= n_mask_cnt;
            r_mpos     <= n_mpos;
            r_remain   <= n_remain;
            r_stopped  <= n_stopped;
        end
    end

endmodule

`default_nettype wire

>>> hdl/wsdf_queue.sv
// Short queue of classified requests between the parser and the output side.
// Depends on wsdf_pkg.
`default_nettype none

module wsdf_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire wsdf_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_rd,
    output logic                o_avail,
    output wsdf_pkg::t_cmd      o_cmd
);

    wsdf_pkg::t_cmd r_mem [wsdf_pkg::QUEUE_DEPTH];
    logic [wsdf_pkg::QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [wsdf_pkg::QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (wsdf_pkg::QUEUE_AW+1)'(wsdf_pkg::QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/wsdf_back.sv
// Output side of the deframer: unmasks payload bytes and holds the result register.
// Depends on wsdf_pkg.
`default_nettype none

module wsdf_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_avail,
    input  wire wsdf_pkg::t_cmd i_cmd,
    output logic                o_take,
    input  wire logic           i_pop,
    output logic                o_empty,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_payload_byte,
    output logic [3:0]          o_opcode,
    output logic                o_fin,
    output logic                o_last,
    output logic [1:0]          o_status,
    output logic [31:0]         o_payload_length
);

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic [3:0]  r_opcode;
    logic        r_fin;
    logic        r_last;
    logic [1:0]  r_status;
    logic [31:0] r_len;

    // Advance when the result register is free or being drained.
    assign o_take = i_avail && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_kind   <= i_cmd.kind;
            r_byte   <= (i_cmd.kind == wsdf_pkg::KIND_PAYLOAD) ? (i_cmd.data ^ i_cmd.key) :
                8'd0;
            r_opcode <= i_cmd.opcode;
            r_fin    <= i_cmd.fin;
            r_last   <= i_cmd.last;
            r_status <= i_cmd.status;
            // Saturate a length that did not fit
            r_len    <= i_cmd.len_ovf ? 32'hFFFF_FFFF : i_cmd.len;
        end
    end

    assign o_empty          = !r_valid;
    assign o_kind           = r_kind;
    assign o_payload_byte   = r_byte;
    assign o_opcode         = r_opcode;
    assign o_fin            = r_fin;
    assign o_last           = r_last;
    assign o_status         = r_status;
    assign o_payload_length = r_len;

endmodule

`default_nettype wire
